// ===== rtl/bcl_pkg.sv =====
package bcl_pkg;

  localparam int ListDepthDef = 16;

  localparam int OpcodeW = 4;
  localparam int PosW    = 5;
  localparam int DataW   = 8;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  localparam logic [OpcodeW-1:0] OP_PUSH_FRONT   = 4'd0;
  localparam logic [OpcodeW-1:0] OP_PUSH_BACK    = 4'd1;
  localparam logic [OpcodeW-1:0] OP_INSERT_AT    = 4'd2;
  localparam logic [OpcodeW-1:0] OP_INSERT_SORT  = 4'd3;
  localparam logic [OpcodeW-1:0] OP_POP_FRONT    = 4'd4;
  localparam logic [OpcodeW-1:0] OP_POP_BACK     = 4'd5;
  localparam logic [OpcodeW-1:0] OP_REMOVE_AT    = 4'd6;
  localparam logic [OpcodeW-1:0] OP_REPLACE      = 4'd7;
  localparam logic [OpcodeW-1:0] OP_READ         = 4'd8;
  localparam logic [OpcodeW-1:0] OP_CLEAR        = 4'd9;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [OpcodeW-1:0]      opcode;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic signed [DataW-1:0] read_value;
    logic [CountW-1:0]       item_count;
    logic                    is_empty;
    logic signed [DataW-1:0] first_value;
    logic signed [DataW-1:0] last_value;
  } rsp_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic wr;
    logic sorted;
    logic at_idx;
    logic after_idx;
    logic live;
  } cell_ctl_t;

endpackage

// ===== rtl/bcl_cell.sv =====
module bcl_cell (
  input  logic                             clk_i,
  input  bcl_pkg::cell_ctl_t               ctl_i,
  input  logic signed [bcl_pkg::DataW-1:0] left_i,
  input  logic signed [bcl_pkg::DataW-1:0] right_i,
  input  logic signed [bcl_pkg::DataW-1:0] val_i,
  input  logic                             prev_i,
  output logic                             prev_o,
  output logic signed [bcl_pkg::DataW-1:0] data_o
);
  import bcl_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;
  logic at_sort, at, after;

  // sorted slot: first live cell not less than the value, else the first free cell
  assign at_sort = !prev_i && (!ctl_i.live || !(data_q < val_i));
  assign prev_o  = prev_i || at_sort;

  assign at    = ctl_i.sorted ? at_sort : ctl_i.at_idx;
  assign after = ctl_i.sorted ? prev_i  : ctl_i.after_idx;

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (after) begin
        data_d = left_i;
      end else if (at) begin
        data_d = val_i;
      end
    end else if (ctl_i.del) begin
      if (at || after) begin
        data_d = right_i;
      end
    end else if (ctl_i.wr && at) begin
      data_d = val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/bounded_char_list_engine.sv =====
// done_o is high in the cycle after start is taken, with the result
// throughput: one command per cycle, every command works on all cells at once
// busy stays low; results cannot be held off by the receiver
// reset clears the count and the result strobe; cell contents stay undefined
// until written and are never observed above the count
module bounded_char_list_engine #(
  parameter int LIST_DEPTH = bcl_pkg::ListDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  bcl_pkg::cmd_t cmd_i,
  output logic          busy,
  output logic          done_o,
  output bcl_pkg::rsp_t rsp_o
);
  import bcl_pkg::*;

  localparam int CntW = $clog2(LIST_DEPTH + 1);
  localparam int CmpW = (CntW > PosW) ? CntW : PosW;

  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [StatusW-1:0]      status_q, status_d;
  logic signed [DataW-1:0] rd_q, rd_d;
  logic                    done_q;

  logic                    accept;
  logic                    full;
  logic [CmpW-1:0]         cnt_ext, pos_ext, k;
  logic                    ins, del, wr, sorted, rd_ok;

  cell_ctl_t               ctl [LIST_DEPTH];
  logic signed [DataW-1:0] data [LIST_DEPTH];
  logic [LIST_DEPTH:0]     prev;
  logic signed [DataW-1:0] rd_sel, last_sel;

  assign accept  = start && !busy;
  assign busy    = 1'b0;
  assign full    = cnt_q == CntW'(LIST_DEPTH);
  assign cnt_ext = CmpW'(cnt_q);
  assign pos_ext = CmpW'(cmd_i.position);

  always_comb begin
    ins      = 1'b0;
    del      = 1'b0;
    wr       = 1'b0;
    sorted   = 1'b0;
    rd_ok    = 1'b0;
    k        = '0;
    status_d = ST_OK;
    cnt_d    = cnt_q;
    unique case (cmd_i.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_SORT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ins    = 1'b1;
          sorted = cmd_i.opcode == OP_INSERT_SORT;
          k      = (cmd_i.opcode == OP_PUSH_BACK) ? cnt_ext : '0;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      OP_INSERT_AT: begin
        if (pos_ext > cnt_ext) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ins   = 1'b1;
          k     = pos_ext;
          cnt_d = cnt_q + 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          del   = cmd_i.opcode == OP_POP_FRONT;
          cnt_d = cnt_q - 1'b1;
        end
      end
      OP_REMOVE_AT, OP_REPLACE, OP_READ: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          k = pos_ext;
          if (cmd_i.opcode == OP_REMOVE_AT) begin
            del   = 1'b1;
            cnt_d = cnt_q - 1'b1;
          end else if (cmd_i.opcode == OP_REPLACE) begin
            wr = 1'b1;
          end else begin
            rd_ok = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign prev[0] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] left, right;

    assign ctl[i].ins       = accept && ins;
    assign ctl[i].del       = accept && del;
    assign ctl[i].wr        = accept && wr;
    assign ctl[i].sorted    = sorted;
    assign ctl[i].at_idx    = CmpW'(i) == k;
    assign ctl[i].after_idx = CmpW'(i) > k;
    assign ctl[i].live      = CmpW'(i) < cnt_ext;

    if (i == 0) begin : g_head
      assign left = data[i];
    end else begin : g_mid
      assign left = data[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_tail
      assign right = data[i];
    end else begin : g_body
      assign right = data[i+1];
    end

    bcl_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl[i]),
      .left_i (left),
      .right_i(right),
      .val_i  (cmd_i.value),
      .prev_i (prev[i]),
      .prev_o (prev[i+1]),
      .data_o (data[i])
    );
  end

  always_comb begin
    rd_sel   = '0;
    last_sel = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (CmpW'(i) == pos_ext) begin
        rd_sel = rd_sel | data[i];
      end
      if (CmpW'(i) == cnt_ext - 1'b1) begin
        last_sel = last_sel | data[i];
      end
    end
  end

  assign rd_d = rd_ok ? rd_sel : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rd_q     <= rd_d;
    end
  end

  assign done_o            = done_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.read_value  = rd_q;
  assign rsp_o.item_count  = CountW'(cnt_q);
  assign rsp_o.is_empty    = cnt_q == '0;
  assign rsp_o.first_value = (cnt_q == '0) ? '0 : data[0];
  assign rsp_o.last_value  = (cnt_q == '0) ? '0 : last_sel;

endmodule

// ===== rtl/bcl_checker.sv =====
module bcl_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input bcl_pkg::cmd_t cmd_i,
  input logic          busy,
  input logic          done_o,
  input bcl_pkg::rsp_t rsp_o
);
  import bcl_pkg::*;

  logic accept;
  assign accept = start && !busy;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("missing result after transfer");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result without transfer");

  a_empty_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.is_empty |-> rsp_o.item_count == '0 && rsp_o.first_value == '0
      && rsp_o.last_value == '0)
    else $error("empty list shows elements");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i.opcode == OP_CLEAR |=> rsp_o.item_count == '0 && rsp_o.status == ST_OK)
    else $error("clear left elements");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(done_o) && rsp_o.status != ST_OK |->
      rsp_o.item_count == $past(rsp_o.item_count))
    else $error("failed command changed the count");

endmodule

bind bounded_char_list_engine bcl_checker u_bcl_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .cmd_i (cmd_i),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);
